FILE: src/crc8fcd_pkg.sv
// Shared constants and types of the CRC-8 framed command decoder.
package crc8fcd_pkg;

  localparam int unsigned MAX_PAYLOAD = 32;
  localparam int unsigned MAX_FRAME   = 37;
  localparam int unsigned HDR_BYTES   = 4;
  localparam int unsigned MIN_FRAME   = 5;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = $clog2(MAX_FRAME + 1);
  localparam int unsigned PAY_AW = $clog2(MAX_PAYLOAD);
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned ERR_W  = 2;
  localparam int unsigned BIT_CNT_W = $clog2(BYTE_W + 1);

  localparam logic [BYTE_W-1:0] CRC_POLY      = 8'h31;
  localparam logic [BYTE_W-1:0] PROTO_VER_RST = 8'h01;

  localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FORMAT = 2'd1;
  localparam logic [ERR_W-1:0] ERR_CRC    = 2'd2;

  typedef struct packed {
    logic clear;
    logic start;
  } crc_ctrl_t;

endpackage

FILE: src/crc8fcd_in_if.sv
// Input channel: one received byte per beat with an end-of-frame mark.
interface crc8fcd_in_if;
  import crc8fcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              end_of_frame;

  modport source (output valid, output rx_byte, output end_of_frame, input ready);
  modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

FILE: src/crc8fcd_out_if.sv
// Output channel: one decode result per beat.
interface crc8fcd_out_if;
  import crc8fcd_pkg::*;

  logic              valid;
  logic              ready;
  logic              frame_ok;
  logic [ERR_W-1:0]  error_code;
  logic [BYTE_W-1:0] msg_type;
  logic [BYTE_W-1:0] seq_num;
  logic [LEN_W-1:0]  payload_len;
  logic [BYTE_W-1:0] payload_byte;
  logic              last_result;

  modport source (output valid, output frame_ok, output error_code, output msg_type,
                  output seq_num, output payload_len, output payload_byte,
                  output last_result, input ready);
  modport sink   (input valid, input frame_ok, input error_code, input msg_type,
                  input seq_num, input payload_len, input payload_byte,
                  input last_result, output ready);
endinterface

FILE: src/crc8fcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module crc8fcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/crc8fcd_crc_unit.sv
// Bit-serial CRC-8 engine: folds one byte into the running CRC, one bit per cycle.
module crc8fcd_crc_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  crc8fcd_pkg::crc_ctrl_t         ctrl_i,
  input  logic [crc8fcd_pkg::BYTE_W-1:0] byte_i,
  output logic [crc8fcd_pkg::BYTE_W-1:0] crc_o,
  output logic                           busy_o
);
  import crc8fcd_pkg::*;

  logic [BYTE_W-1:0]    crc_q, crc_d;
  logic [BIT_CNT_W-1:0] bits_q, bits_d;

  always_comb begin
    crc_d  = crc_q;
    bits_d = bits_q;
    if (ctrl_i.clear) begin
      crc_d  = '0;
      bits_d = '0;
    end else if (ctrl_i.start) begin
      crc_d  = crc_q ^ byte_i;
      bits_d = BIT_CNT_W'(BYTE_W);
    end else if (bits_q != '0) begin
      crc_d  = crc_q[BYTE_W-1] ? ({crc_q[BYTE_W-2:0], 1'b0} ^ CRC_POLY)
                               : {crc_q[BYTE_W-2:0], 1'b0};
      bits_d = bits_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= '0;
      bits_q <= '0;
    end else begin
      crc_q  <= crc_d;
      bits_q <= bits_d;
    end
  end

  assign crc_o  = crc_q;
  assign busy_o = (bits_q != '0);

  // A new byte may only be folded in once the previous one is finished.
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> !busy_o)
    else $error("CRC start while busy");

  a_busy_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.start && !ctrl_i.clear) |=> (bits_q == BIT_CNT_W'(BYTE_W)))
    else $error("CRC bit counter not loaded");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> (crc_q == '0 && !busy_o))
    else $error("CRC not cleared");

endmodule

FILE: src/crc8_framed_command_decoder_core.sv
// Top level of the CRC-8 framed command decoder.
// The block takes one frame byte per input beat; each kept byte is folded into a
// CRC-8 (polynomial 0x31) one bit per cycle, and the input is held not ready while
// that runs (accept, the CRC bit steps, return to idle); a byte past the frame
// limit without an end mark is accepted and dropped. At the end mark the frame is
// checked in the check state; a failed or empty frame then gives one result, and a
// valid frame replays its payload from a 32-entry RAM, each result passing through
// read, load and present, and present is held while the sink holds ready low. The next
// frame's first byte can be accepted the cycle after the last result beat.
module crc8_framed_command_decoder_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [crc8fcd_pkg::BYTE_W-1:0] cfg_wdata_i,
  crc8fcd_in_if.sink                     in_i,
  crc8fcd_out_if.source                  out_o
);
  import crc8fcd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CRC   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [BYTE_W-1:0] version_q;
  logic [CNT_W-1:0]  byte_count_q, byte_count_d;
  logic [BYTE_W-1:0] crc_before_q, crc_before_d;
  logic [BYTE_W-1:0] newest_q, newest_d;
  logic [BYTE_W-1:0] version_seen_q, version_seen_d;
  logic [BYTE_W-1:0] type_seen_q, type_seen_d;
  logic [BYTE_W-1:0] seq_seen_q, seq_seen_d;
  logic [BYTE_W-1:0] length_seen_q, length_seen_d;
  logic              eof_q, eof_d;
  logic [PAY_AW-1:0] idx_q, idx_d;

  logic              ok_q, ok_d;
  logic [ERR_W-1:0]  err_q, err_d;
  logic [BYTE_W-1:0] type_q, type_d;
  logic [BYTE_W-1:0] seq_q, seq_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [BYTE_W-1:0] pb_q, pb_d;
  logic              last_q, last_d;

  logic              in_acc, out_acc, keep;
  logic              len_err, crc_err;
  logic              ram_we, ram_re;
  logic [PAY_AW-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [CNT_W-1:0]  pay_pos;
  crc_ctrl_t         crc_ctrl;
  logic [BYTE_W-1:0] crc_running;
  logic              crc_busy;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_o.valid = (state_q == S_OUT);
  assign out_acc    = out_o.valid && out_o.ready;

  assign keep      = (byte_count_q < CNT_W'(MAX_FRAME));
  assign pay_pos   = byte_count_q - CNT_W'(HDR_BYTES);
  assign ram_we    = in_acc && keep && (byte_count_q >= CNT_W'(HDR_BYTES))
                     && (pay_pos < CNT_W'(MAX_PAYLOAD));
  assign ram_waddr = pay_pos[PAY_AW-1:0];
  assign ram_re    = (state_q == S_READ);

  // Checks run in a fixed priority: format first, CRC only on a well-formed frame.
  assign len_err = (byte_count_q < CNT_W'(MIN_FRAME))
                || (version_seen_q != version_q)
                || (length_seen_q > BYTE_W'(MAX_PAYLOAD))
                || ((9'(length_seen_q) + 9'(MIN_FRAME)) != 9'(byte_count_q));
  assign crc_err = (newest_q != crc_before_q);

  assign crc_ctrl.start = in_acc && keep;
  assign crc_ctrl.clear = out_acc && last_q;

  always_comb begin
    state_d        = state_q;
    byte_count_d   = byte_count_q;
    crc_before_d   = crc_before_q;
    newest_d       = newest_q;
    version_seen_d = version_seen_q;
    type_seen_d    = type_seen_q;
    seq_seen_d     = seq_seen_q;
    length_seen_d  = length_seen_q;
    eof_d          = eof_q;
    idx_d          = idx_q;
    ok_d           = ok_q;
    err_d          = err_q;
    type_d         = type_q;
    seq_d          = seq_q;
    len_d          = len_q;
    pb_d           = pb_q;
    last_d         = last_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          eof_d = in_i.end_of_frame;
          if (keep) begin
            crc_before_d = crc_running;
            newest_d     = in_i.rx_byte;
            byte_count_d = byte_count_q + 1'b1;
            case (byte_count_q)
              CNT_W'(0): version_seen_d = in_i.rx_byte;
              CNT_W'(1): type_seen_d    = in_i.rx_byte;
              CNT_W'(2): seq_seen_d     = in_i.rx_byte;
              CNT_W'(3): length_seen_d  = in_i.rx_byte;
              default: ;
            endcase
            state_d = S_CRC;
          end else if (in_i.end_of_frame) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CRC: begin
        if (!crc_busy) begin
          state_d = eof_q ? S_CHECK : S_IDLE;
        end
      end
      S_CHECK: begin
        ok_d   = 1'b0;
        err_d  = ERR_OK;
        type_d = '0;
        seq_d  = '0;
        len_d  = '0;
        pb_d   = '0;
        last_d = 1'b1;
        idx_d  = '0;
        if (len_err) begin
          err_d   = ERR_FORMAT;
          state_d = S_OUT;
        end else if (crc_err) begin
          err_d   = ERR_CRC;
          state_d = S_OUT;
        end else if (length_seen_q == '0) begin
          ok_d    = 1'b1;
          type_d  = type_seen_q;
          seq_d   = seq_seen_q;
          state_d = S_OUT;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        ok_d    = 1'b1;
        err_d   = ERR_OK;
        type_d  = type_seen_q;
        seq_d   = seq_seen_q;
        len_d   = length_seen_q[LEN_W-1:0];
        pb_d    = ram_rdata;
        last_d  = ((BYTE_W'(idx_q) + 1'b1) == length_seen_q);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          if (last_q) begin
            byte_count_d   = '0;
            crc_before_d   = '0;
            newest_d       = '0;
            version_seen_d = '0;
            type_seen_d    = '0;
            seq_seen_d     = '0;
            length_seen_d  = '0;
            eof_d          = 1'b0;
            state_d        = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      version_q      <= PROTO_VER_RST;
      byte_count_q   <= '0;
      crc_before_q   <= '0;
      newest_q       <= '0;
      version_seen_q <= '0;
      type_seen_q    <= '0;
      seq_seen_q     <= '0;
      length_seen_q  <= '0;
      eof_q          <= 1'b0;
      idx_q          <= '0;
    end else begin
      state_q        <= state_d;
      byte_count_q   <= byte_count_d;
      crc_before_q   <= crc_before_d;
      newest_q       <= newest_d;
      version_seen_q <= version_seen_d;
      type_seen_q    <= type_seen_d;
      seq_seen_q     <= seq_seen_d;
      length_seen_q  <= length_seen_d;
      eof_q          <= eof_d;
      idx_q          <= idx_d;
      if (cfg_we_i) begin
        version_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q   <= ok_d;
    err_q  <= err_d;
    type_q <= type_d;
    seq_q  <= seq_d;
    len_q  <= len_d;
    pb_q   <= pb_d;
    last_q <= last_d;
  end

  assign out_o.frame_ok     = ok_q;
  assign out_o.error_code   = err_q;
  assign out_o.msg_type     = type_q;
  assign out_o.seq_num      = seq_q;
  assign out_o.payload_len  = len_q;
  assign out_o.payload_byte = pb_q;
  assign out_o.last_result  = last_q;

  crc8fcd_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .byte_i (in_i.rx_byte),
    .crc_o  (crc_running),
    .busy_o (crc_busy)
  );

  crc8fcd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.rx_byte),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= CNT_W'(MAX_FRAME))
    else $error("byte count past frame limit");

  a_ok_matches_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.frame_ok == (out_o.error_code == ERR_OK)))
    else $error("frame_ok disagrees with error code");

  a_last_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_q) |=> (in_i.ready && byte_count_q == '0))
    else $error("frame state not released after last result");

  a_crc_idle_on_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> !crc_busy)
    else $error("frame checked while CRC still running");

endmodule
